@@ hw/rtl/hte_pkg.sv @@
// Shared types, constants and helper functions of the hash table engine.
package hte_pkg;

    localparam int KEY_W      = 64;
    localparam int VAL_W      = 64;
    localparam int ENTRY_W    = 7;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int STEP_W     = 3;

    localparam logic [KEY_W-1:0]   HASH_START = 64'd5381;
    localparam int                 HASH_SHIFT = 5;
    localparam logic [STEP_W-1:0]  MOD_LAST_STEP = 3'd7;

    // Operation codes of an input word.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_BYTES = 1'd1;

    localparam logic [CFG_DATA_W-1:0] BYTES_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic [VAL_W-1:0]   read_value;
        logic [ENTRY_W-1:0] entry_count;
        logic               status;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic load;
        logic hash_step;
        logic mod_step;
        logic rd;
        logic eval;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic mod_last;
        logic out_free;
    } t_sts;

    function automatic logic [CFG_DATA_W-1:0] clamp_bytes(
        input logic [CFG_DATA_W-1:0] n,
        input logic [CFG_DATA_W-1:0] maxn
    );
        logic [CFG_DATA_W-1:0] r;
        r = n;
        if (n == '0) r = 4'd1;
        if (n > maxn) r = maxn;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] byte_mask(input logic [CFG_DATA_W-1:0] n);
        logic [KEY_W-1:0] m;
        m = '1;
        if (n < 4'd8) m = (64'd1 << {n, 3'b000}) - 64'd1;
        return m;
    endfunction

endpackage

@@ hw/rtl/hte_hash.sv @@
// Iterative djb2 hash, one byte a cycle, followed by a remainder by the bucket count.
module hte_hash #(
    parameter int BUCKETS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [hte_pkg::KEY_W-1:0]  i_key,
    input  logic [hte_pkg::CFG_DATA_W-1:0] i_kb,
    input  logic                       i_hash_step,
    input  logic                       i_mod_step,
    output logic                       o_hash_last,
    output logic                       o_mod_last,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);

    localparam int BW = $clog2(BUCKETS);
    localparam logic [BW:0] BKT = (BW+1)'(BUCKETS);

    logic [hte_pkg::KEY_W-1:0]  r_hkey;
    logic [hte_pkg::KEY_W-1:0]  r_hash;
    logic [BW-1:0]              r_rem;
    logic [hte_pkg::STEP_W-1:0] r_step;
    logic [BW-1:0]              n_rem;

    assign o_hash_last = ({1'b0, r_step} == (i_kb - 4'd1));
    assign o_mod_last  = (r_step == hte_pkg::MOD_LAST_STEP);
    assign o_bucket    = r_rem;

    // Eight restoring remainder steps on the top byte of the hash; the
    // partial remainder never exceeds the bucket count, so it stays narrow.
    always_comb begin
        logic [BW:0]   t;
        logic [BW-1:0] r;
        r = r_rem;
        t = '0;
        for (int i = hte_pkg::BYTE_W - 1; i >= 0; i--) begin
            t = {r, r_hash[hte_pkg::KEY_W - hte_pkg::BYTE_W + i]};
            if (t >= BKT) t = t - BKT;
            r = t[BW-1:0];
        end
        n_rem = r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_load) begin
            r_step <= '0;
        end else if (i_hash_step) begin
            r_step <= o_hash_last ? '0 : r_step + 3'd1;
        end else if (i_mod_step) begin
            r_step <= r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hkey <= i_key;
            r_hash <= hte_pkg::HASH_START;
            r_rem  <= '0;
        end else if (i_hash_step) begin
            r_hash <= (r_hash << hte_pkg::HASH_SHIFT) + r_hash
                      + {56'd0, r_hkey[hte_pkg::BYTE_W-1:0]};
            r_hkey <= r_hkey >> hte_pkg::BYTE_W;
        end else if (i_mod_step) begin
            r_hash <= r_hash << hte_pkg::BYTE_W;
            r_rem  <= n_rem;
        end
    end

endmodule

@@ hw/rtl/hte_dp.sv @@
// Datapath: configuration, bucket memories, way compare, entry count and result register.
module hte_dp #(
    parameter int BUCKETS         = 16,
    parameter int WAYS            = 4,
    parameter int MAX_KEY_BYTES   = 8,
    parameter int MAX_VALUE_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hte_pkg::t_cmd                     i_cmd,
    output hte_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic [hte_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hte_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  hte_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output hte_pkg::t_out_word                o_out_word
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOTS = BUCKETS * WAYS;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int KW    = hte_pkg::KEY_W;
    localparam int VW    = hte_pkg::VAL_W;

    logic [KW*WAYS-1:0] key_mem [BUCKETS];
    logic [VW*WAYS-1:0] val_mem [BUCKETS];
    logic [WAYS-1:0]    vld_mem [BUCKETS];

    logic [hte_pkg::CFG_DATA_W-1:0] r_key_bytes, r_value_bytes;
    logic [1:0]          r_op;
    logic [KW-1:0]       r_key;
    logic [VW-1:0]       r_val;
    logic [KW*WAYS-1:0]  r_key_row;
    logic [VW*WAYS-1:0]  r_val_row;
    logic [WAYS-1:0]     r_vld_row;
    logic [CW-1:0]       r_count;
    logic [BW-1:0]       r_clr_addr;
    logic                r_out_valid;
    hte_pkg::t_out_word  r_out;

    logic [hte_pkg::CFG_DATA_W-1:0] kb, vb;
    logic [KW-1:0]       kmask, vmask;
    logic [BW-1:0]       bucket;
    logic [WAYS-1:0]     match_v;
    logic                found_any, free_any;
    logic [WW-1:0]       hit_w, free_w, tgt_w;
    logic [VW-1:0]       hit_val;
    logic [KW*WAYS-1:0]  key_row_new;
    logic [VW*WAYS-1:0]  val_row_new;
    logic [WAYS-1:0]     vld_row_upd;
    logic                key_we, val_we, vld_upd;
    logic                vld_we;
    logic [BW-1:0]       vld_addr;
    logic [WAYS-1:0]     vld_data;
    logic [CW-1:0]       n_count;
    hte_pkg::t_out_word  n_out;

    assign kb    = hte_pkg::clamp_bytes(r_key_bytes, 4'(MAX_KEY_BYTES));
    assign vb    = hte_pkg::clamp_bytes(r_value_bytes, 4'(MAX_VALUE_BYTES));
    assign kmask = hte_pkg::byte_mask(kb);
    assign vmask = hte_pkg::byte_mask(vb);

    hte_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (i_cmd.load),
        .i_key       (i_in_word.key & kmask),
        .i_kb        (kb),
        .i_hash_step (i_cmd.hash_step),
        .i_mod_step  (i_cmd.mod_step),
        .o_hash_last (o_sts.hash_last),
        .o_mod_last  (o_sts.mod_last),
        .o_bucket    (bucket)
    );

    assign o_sts.clr_last = (r_clr_addr == BW'(BUCKETS - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Parallel compare of the ways; the lowest matching and lowest free way win.
    always_comb begin
        hit_w  = '0;
        free_w = '0;
        for (int w = 0; w < WAYS; w++) begin
            match_v[w] = r_vld_row[w] && ((r_key_row[w*KW +: KW] & kmask) == r_key);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match_v[w])    hit_w  = WW'(w);
            if (!r_vld_row[w]) free_w = WW'(w);
        end
        found_any = |match_v;
        free_any  = !(&r_vld_row);
        tgt_w     = found_any ? hit_w : free_w;
        hit_val   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (WW'(w) == hit_w) hit_val = r_val_row[w*VW +: VW];
            key_row_new[w*KW +: KW] = (WW'(w) == tgt_w) ? r_key : r_key_row[w*KW +: KW];
            val_row_new[w*VW +: VW] = (WW'(w) == tgt_w) ? r_val : r_val_row[w*VW +: VW];
        end
    end

    always_comb begin
        key_we      = 1'b0;
        val_we      = 1'b0;
        vld_upd     = 1'b0;
        vld_row_upd = r_vld_row;
        n_count     = r_count;
        n_out       = '0;
        n_out.found = found_any;
        case (r_op)
            hte_pkg::OP_INSERT: begin
                if (found_any) begin
                    val_we = 1'b1;
                end else if (free_any) begin
                    key_we             = 1'b1;
                    val_we             = 1'b1;
                    vld_upd            = 1'b1;
                    vld_row_upd[tgt_w] = 1'b1;
                    n_count            = r_count + CW'(1);
                end else begin
                    n_out.status = 1'b1;
                end
            end
            hte_pkg::OP_LOOKUP: begin
                if (found_any) n_out.read_value = hit_val & vmask;
            end
            hte_pkg::OP_REMOVE: begin
                if (found_any) begin
                    vld_upd            = 1'b1;
                    vld_row_upd[hit_w] = 1'b0;
                    if (r_count != '0) n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_out.found = 1'b0;
            end
        endcase
        n_out.entry_count = hte_pkg::ENTRY_W'(n_count);
    end

    // One write port on the valid memory, shared by the clearing pass.
    assign vld_we   = i_cmd.clr || (i_cmd.eval && vld_upd);
    assign vld_addr = i_cmd.clr ? r_clr_addr : bucket;
    assign vld_data = i_cmd.clr ? '0 : vld_row_upd;

    always_ff @(posedge i_clk) begin
        if (vld_we) vld_mem[vld_addr] <= vld_data;
        if (i_cmd.eval && key_we) key_mem[bucket] <= key_row_new;
        if (i_cmd.eval && val_we) val_mem[bucket] <= val_row_new;
        if (i_cmd.rd) begin
            r_key_row <= key_mem[bucket];
            r_val_row <= val_mem[bucket];
            r_vld_row <= vld_mem[bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_word.operation;
            r_key <= i_in_word.key & kmask;
            r_val <= i_in_word.value & vmask;
        end
        if (i_cmd.eval) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes   <= hte_pkg::BYTES_RESET;
            r_value_bytes <= hte_pkg::BYTES_RESET;
            r_count       <= '0;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hte_pkg::CFG_KEY_BYTES:   r_key_bytes   <= i_cfg_data;
                    hte_pkg::CFG_VALUE_BYTES: r_value_bytes <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + BW'(1);
            if (i_cmd.eval) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ hw/rtl/hte_ctrl.sv @@
// Controller: sequences clearing, hashing, remainder, bucket read and evaluation.
module hte_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  hte_pkg::t_sts i_sts,
    output hte_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_READ,
        ST_EVAL
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_HASH;
                end
            end
            ST_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_last) n_state = ST_MOD;
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_sts.out_free) begin
                    o_cmd.eval = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != ST_IDLE);
        end
    end

    assign o_in_stall = r_stall;

endmodule

@@ hw/rtl/hash_table_engine.sv @@
// Top level of the hash table engine: a djb2-hashed bucket table of keys and values.
// An accepted word is hashed one key byte a cycle over the clamped key byte count, then
// reduced by the remainder steps, then its bucket is read and evaluated; evaluation waits
// while the result register is full and stalled. No new word is taken until it is done.
// Reset: synchronous, active low; after it a clearing pass empties the valid memory one
// bucket a cycle, and no input word is taken until it has finished.
module hash_table_engine #(
    parameter int BUCKETS         = 16,
    parameter int WAYS            = 4,
    parameter int MAX_KEY_BYTES   = 8,
    parameter int MAX_VALUE_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hte_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hte_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  hte_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output hte_pkg::t_out_word             o_out_word
);

    // The controller owns the sequence of an operation; the datapath owns the
    // memories, the hash unit and the result register. They talk only through
    // the command and status structures below.
    hte_pkg::t_cmd cmd;
    hte_pkg::t_sts sts;

    // Each bucket is one row of the key, value and valid memories, so a single
    // read fetches all of its ways for a parallel compare. An update writes
    // the whole row back with the one changed way spliced in.
    hte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The result word sits in a register of its own, so the next input word
    // is taken while an earlier result still waits downstream; evaluation of
    // the next word waits only if that register is still full and stalled.
    hte_dp #(
        .BUCKETS         (BUCKETS),
        .WAYS            (WAYS),
        .MAX_KEY_BYTES   (MAX_KEY_BYTES),
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // A dropped insert never reports the key as present.
    a_status_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status) |-> !o_out_word.found)
        else $error("full-bucket status with found set");

    // A non-zero read value only comes from a hit.
    a_value_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.read_value != '0)) |-> o_out_word.found)
        else $error("read value returned without a hit");

    // One word at a time: an accepted word closes the input until it is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word accepted while one is in flight");

    // A fresh result comes only from a word that was being processed.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a word in flight");

endmodule
